[sv/grid_hotspot_centroid_assert.svh]
// assertion macros for the grid hot-spot centroid block
// expects aclk and aresetn in the scope of each use
`ifndef GRID_HOTSPOT_CENTROID_ASSERT_SVH
`define GRID_HOTSPOT_CENTROID_ASSERT_SVH
`ifndef ASSERT_OFF
`define GHC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
`define GHC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GHC_ASSERT(lbl, prop, msg)
`define GHC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[sv/ghc_pkg.sv]
// shared constants, types and helper functions of the grid hot-spot centroid block
// no dependencies
`default_nettype none
package ghc_pkg;
    localparam int ROWS        = 16;
    localparam int COLS        = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int CELLS       = ROWS * COLS;

    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int LN_W   = $clog2(CELLS + 1);

    localparam int S_W   = SAMPLE_BITS + LN_W;
    localparam int Q_W   = 2 * SAMPLE_BITS + LN_W;
    localparam int V_W   = 2 * SAMPLE_BITS + 2 * LN_W;
    localparam int VH_W  = V_W / 2;
    localparam int VU_W  = V_W - VH_W;
    localparam int KK_W  = 16;
    localparam int RHS_W = V_W + KK_W;
    localparam int DD_W  = 2 * S_W;

    localparam int HC_W   = LN_W;
    localparam int FCOL_W = $clog2(2 * COLS);
    localparam int FROW_W = (ROWS > 2) ? $clog2(ROWS / 2) : 1;
    localparam int RSUM_W = $clog2(CELLS * ((ROWS - 1) / 2) + 1) + 1;
    localparam int CSUM_W = $clog2(CELLS * (2 * COLS - 1) + 1);
    localparam int DIV_W  = ((RSUM_W > CSUM_W) ? RSUM_W : CSUM_W) + 8;
    localparam int STEP_W = $clog2(DIV_W);

    localparam int KIND_W   = 2;
    localparam int IN_ROW_W = 4;
    localparam int IN_COL_W = 6;
    localparam int SMP_W    = 16;
    localparam int HOT_W    = 11;
    localparam int CROW_W   = 11;
    localparam int CCOL_W   = 15;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 40;

    localparam int K_W       = 8;
    localparam int APB_A_W   = 3;
    localparam int APB_D_W   = 32;
    localparam logic [K_W-1:0] K_RESET = 8'd80;
    localparam logic [APB_A_W-1:0] REG_ADDR_THRESHOLD = 3'd0;

    localparam int WAIT_W     = 3;
    localparam int STAT_DRAIN = 4;
    localparam int CALC_WAIT  = 6;
    localparam int HOT_DRAIN  = 5;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE  = 2'd0,
        KIND_CLEAR  = 2'd1,
        KIND_LOCATE = 2'd2
    } kind_t;

    typedef struct packed {
        logic             wr_item;
        logic             clr_wr;
        logic             sweep_rd;
        logic             hot_mode;
        logic             acc_clr;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             div_start;
        logic             div_sel;
        logic             load_qr;
        logic             load_qc;
        logic             out_load;
    } ghc_cmd_t;

    typedef struct packed {
        logic div_done;
        logic hot_none;
        logic out_free;
    } ghc_stat_t;

    function automatic logic [ROW_W-1:0] mod_row(input logic [IN_ROW_W-1:0] r);
        logic [ROW_W-1:0] res;
        res = '0;
        for (int i = 0; i < (1 << IN_ROW_W); i++) begin
            if (r == IN_ROW_W'(i)) res = ROW_W'(i % ROWS);
        end
        return res;
    endfunction

    function automatic logic [COL_W-1:0] mod_col(input logic [IN_COL_W-1:0] c);
        logic [COL_W-1:0] res;
        res = '0;
        for (int i = 0; i < (1 << IN_COL_W); i++) begin
            if (c == IN_COL_W'(i)) res = COL_W'(i % COLS);
        end
        return res;
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
        return ADDR_W'(ADDR_W'(r) * ADDR_W'(COLS) + ADDR_W'(c));
    endfunction
endpackage
`default_nettype wire

[sv/ghc_div.sv]
// restoring divider, one quotient bit per cycle
// depends on ghc_pkg
`default_nettype none
`include "grid_hotspot_centroid_assert.svh"
module ghc_div (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     start,
    input  wire logic [ghc_pkg::DIV_W-1:0] num,
    input  wire logic [ghc_pkg::HC_W-1:0]  den,
    output logic                          done,
    output logic [ghc_pkg::DIV_W-1:0]     quot
);
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [ghc_pkg::STEP_W-1:0]    step_reg, step_next;
    logic [ghc_pkg::HC_W-1:0]      rem_reg, rem_next;
    logic [ghc_pkg::DIV_W-1:0]     num_reg, num_next;
    logic [ghc_pkg::DIV_W-1:0]     quot_reg, quot_next;
    logic [ghc_pkg::HC_W:0]        trial;
    logic                          ge;

    assign trial = {rem_reg, num_reg[ghc_pkg::DIV_W-1]};
    assign ge    = trial >= {1'b0, den};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        num_next  = num_reg;
        quot_next = quot_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = ghc_pkg::STEP_W'(ghc_pkg::DIV_W - 1);
            rem_next  = '0;
            num_next  = num;
            quot_next = '0;
        end else if (busy_reg) begin
            rem_next  = ge ? ghc_pkg::HC_W'(trial - {1'b0, den}) : ghc_pkg::HC_W'(trial);
            num_next  = num_reg << 1;
            quot_next = {quot_reg[ghc_pkg::DIV_W-2:0], ge};
            step_next = step_reg - 1'b1;
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rem_reg  <= rem_next;
        num_reg  <= num_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

    `GHC_ASSERT_NEXT(a_div_start_busy, start, busy_reg, "divider not busy after start")
    `GHC_ASSERT(a_div_done_idle, !(done_reg && busy_reg), "divider done while still busy")
endmodule
`default_nettype wire

[sv/ghc_dp.sv]
// datapath: sample memory, statistics and threshold pipelines, divider, result register
// depends on ghc_pkg and ghc_div
`default_nettype none
`include "grid_hotspot_centroid_assert.svh"
module ghc_dp (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire ghc_pkg::ghc_cmd_t             cmd,
    output ghc_pkg::ghc_stat_t                 stat,
    input  wire logic [ghc_pkg::IN_ROW_W-1:0]  in_row,
    input  wire logic [ghc_pkg::IN_COL_W-1:0]  in_col,
    input  wire logic [ghc_pkg::SMP_W-1:0]     in_sample,
    input  wire logic [ghc_pkg::K_W-1:0]       factor,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [ghc_pkg::M_DATA_W-1:0]       m_tdata
);
    localparam int SB = ghc_pkg::SAMPLE_BITS;

    logic [SB-1:0] mem [ghc_pkg::CELLS];
    logic [ghc_pkg::ADDR_W-1:0] wr_addr, rd_addr;
    logic [SB-1:0] wr_data;
    logic          wr_en;

    logic [SB-1:0]               rd_data_reg;
    logic                        p1_vld_reg;
    logic [ghc_pkg::ROW_W-1:0]   p1_row_reg, p2_row_reg, p3_row_reg;
    logic [ghc_pkg::COL_W-1:0]   p1_col_reg, p2_col_reg, p3_col_reg;
    logic                        p2_vld_reg, p3_hot_reg;
    logic [SB-1:0]               v2_reg;
    logic [2*SB-1:0]             sq_reg;
    logic [ghc_pkg::S_W-1:0]     d_reg, nv;
    logic                        pos_reg;
    logic [ghc_pkg::DD_W-1:0]    dd_reg;

    logic [ghc_pkg::S_W-1:0]     s_acc_reg;
    logic [ghc_pkg::Q_W-1:0]     q_acc_reg;
    logic [ghc_pkg::KK_W-1:0]    kk_reg;
    logic [ghc_pkg::V_W-1:0]     nq_reg, ss_reg, var_reg;
    logic [ghc_pkg::VH_W+ghc_pkg::KK_W-1:0] plo_reg;
    logic [ghc_pkg::VU_W+ghc_pkg::KK_W-1:0] phi_reg;
    logic [ghc_pkg::RHS_W-1:0]   rhs_reg;

    logic [ghc_pkg::HC_W-1:0]    hc_reg;
    logic [ghc_pkg::RSUM_W-1:0]  rsum_reg;
    logic [ghc_pkg::CSUM_W-1:0]  csum_reg;
    logic                        is_hot;
    logic [ghc_pkg::FCOL_W-1:0]  fold_col;
    logic [ghc_pkg::FROW_W-1:0]  fold_row;

    logic [ghc_pkg::DIV_W-1:0]   div_num, div_quot;
    logic                        div_done;
    logic [ghc_pkg::CROW_W-1:0]  qr_reg;
    logic [ghc_pkg::CCOL_W-1:0]  qc_reg;

    logic                        out_vld_reg;
    logic                        out_found_reg;
    logic [ghc_pkg::HOT_W-1:0]   out_hc_reg;
    logic [ghc_pkg::CROW_W-1:0]  out_rq_reg;
    logic [ghc_pkg::CCOL_W-1:0]  out_cq_reg;

    // sample memory
    assign wr_en   = cmd.wr_item || cmd.clr_wr;
    assign wr_addr = cmd.clr_wr ? ghc_pkg::cell_addr(cmd.row, cmd.col)
                   : ghc_pkg::cell_addr(ghc_pkg::mod_row(in_row), ghc_pkg::mod_col(in_col));
    assign wr_data = cmd.clr_wr ? '0 : SB'(in_sample);
    assign rd_addr = ghc_pkg::cell_addr(cmd.row, cmd.col);

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (cmd.sweep_rd) rd_data_reg <= mem[rd_addr];
    end

    // sweep pipeline
    assign nv = ghc_pkg::S_W'(rd_data_reg) * ghc_pkg::S_W'(ghc_pkg::CELLS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_hot_reg <= 1'b0;
        end else begin
            p1_vld_reg <= cmd.sweep_rd;
            p2_vld_reg <= p1_vld_reg;
            p3_hot_reg <= p2_vld_reg && cmd.hot_mode && pos_reg;
        end
        p1_row_reg <= cmd.row;
        p1_col_reg <= cmd.col;
        p2_row_reg <= p1_row_reg;
        p2_col_reg <= p1_col_reg;
        p3_row_reg <= p2_row_reg;
        p3_col_reg <= p2_col_reg;
        v2_reg     <= rd_data_reg;
        sq_reg     <= (2*SB)'(rd_data_reg) * (2*SB)'(rd_data_reg);
        pos_reg    <= nv > s_acc_reg;
        d_reg      <= nv - s_acc_reg;
        dd_reg     <= ghc_pkg::DD_W'(d_reg) * ghc_pkg::DD_W'(d_reg);
    end

    // statistics and threshold
    always_ff @(posedge aclk) begin
        if (cmd.acc_clr) begin
            s_acc_reg <= '0;
            q_acc_reg <= '0;
        end else if (p2_vld_reg && !cmd.hot_mode) begin
            s_acc_reg <= s_acc_reg + ghc_pkg::S_W'(v2_reg);
            q_acc_reg <= q_acc_reg + ghc_pkg::Q_W'(sq_reg);
        end
        kk_reg  <= ghc_pkg::KK_W'(factor) * ghc_pkg::KK_W'(factor);
        nq_reg  <= ghc_pkg::V_W'(q_acc_reg) * ghc_pkg::V_W'(ghc_pkg::CELLS);
        ss_reg  <= ghc_pkg::V_W'(s_acc_reg) * ghc_pkg::V_W'(s_acc_reg);
        var_reg <= nq_reg - ss_reg;
        plo_reg <= (ghc_pkg::VH_W + ghc_pkg::KK_W)'(var_reg[ghc_pkg::VH_W-1:0])
                 * (ghc_pkg::VH_W + ghc_pkg::KK_W)'(kk_reg);
        phi_reg <= (ghc_pkg::VU_W + ghc_pkg::KK_W)'(var_reg[ghc_pkg::V_W-1:ghc_pkg::VH_W])
                 * (ghc_pkg::VU_W + ghc_pkg::KK_W)'(kk_reg);
        rhs_reg <= (ghc_pkg::RHS_W'(phi_reg) << ghc_pkg::VH_W) + ghc_pkg::RHS_W'(plo_reg);
    end

    // hot cell accumulation on folded coordinates
    assign is_hot   = p3_hot_reg &&
                      (ghc_pkg::RHS_W'({dd_reg, 8'b0}) > rhs_reg);
    assign fold_row = ghc_pkg::FROW_W'(p3_row_reg >> 1);
    assign fold_col = p3_row_reg[0]
                    ? ghc_pkg::FCOL_W'(ghc_pkg::FCOL_W'(ghc_pkg::COLS)
                                       + ghc_pkg::FCOL_W'(p3_col_reg))
                    : ghc_pkg::FCOL_W'(p3_col_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.acc_clr) begin
            hc_reg   <= '0;
            rsum_reg <= '0;
            csum_reg <= '0;
        end else if (is_hot) begin
            hc_reg   <= hc_reg + 1'b1;
            rsum_reg <= rsum_reg + ghc_pkg::RSUM_W'(fold_row);
            csum_reg <= csum_reg + ghc_pkg::CSUM_W'(fold_col);
        end
    end

    // centroid division
    assign div_num = cmd.div_sel ? (ghc_pkg::DIV_W'(csum_reg) << 8)
                                 : (ghc_pkg::DIV_W'(rsum_reg) << 8);

    ghc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (hc_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (cmd.acc_clr) begin
            qr_reg <= '0;
            qc_reg <= '0;
        end else begin
            if (cmd.load_qr) qr_reg <= div_quot[ghc_pkg::CROW_W-1:0];
            if (cmd.load_qc) qc_reg <= div_quot[ghc_pkg::CCOL_W-1:0];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            out_found_reg <= hc_reg != '0;
            out_hc_reg    <= ghc_pkg::HOT_W'(hc_reg);
            out_rq_reg    <= qr_reg;
            out_cq_reg    <= qc_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = ghc_pkg::M_DATA_W'({out_cq_reg, out_rq_reg, out_hc_reg, out_found_reg});

    assign stat.div_done = div_done;
    assign stat.hot_none = hc_reg == '0;
    assign stat.out_free = !out_vld_reg || m_tready;

    `GHC_ASSERT_NEXT(a_stats_hold, cmd.hot_mode, $stable(s_acc_reg), "statistics moved in hot pass")
    `GHC_ASSERT(a_no_overwrite, !(cmd.out_load && out_vld_reg && !m_tready), "result overwritten")
    `GHC_ASSERT(a_hot_bound, hc_reg <= ghc_pkg::HC_W'(ghc_pkg::CELLS), "hot count beyond grid size")
endmodule
`default_nettype wire

[sv/ghc_ctrl.sv]
// controller state machine: request decode, clear and locate sweeps, division sequencing
// depends on ghc_pkg
`default_nettype none
module ghc_ctrl (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    input  wire logic [ghc_pkg::KIND_W-1:0]  in_kind,
    output logic                             in_ready,
    output ghc_pkg::ghc_cmd_t                cmd,
    input  wire ghc_pkg::ghc_stat_t          stat
);
    typedef enum logic [11:0] {
        ST_CLEAR      = 12'b0000_0000_0001,
        ST_IDLE       = 12'b0000_0000_0010,
        ST_STAT       = 12'b0000_0000_0100,
        ST_STAT_DRAIN = 12'b0000_0000_1000,
        ST_CALC       = 12'b0000_0001_0000,
        ST_HOT        = 12'b0000_0010_0000,
        ST_HOT_DRAIN  = 12'b0000_0100_0000,
        ST_DIVR       = 12'b0000_1000_0000,
        ST_DIVR_WAIT  = 12'b0001_0000_0000,
        ST_DIVC       = 12'b0010_0000_0000,
        ST_DIVC_WAIT  = 12'b0100_0000_0000,
        ST_OUT        = 12'b1000_0000_0000
    } state_t;

    state_t                     state_reg, state_next;
    logic [ghc_pkg::ROW_W-1:0]  row_reg, row_next;
    logic [ghc_pkg::COL_W-1:0]  col_reg, col_next;
    logic [ghc_pkg::WAIT_W-1:0] wait_reg, wait_next;
    logic                       last_cell;

    assign last_cell = (row_reg == ghc_pkg::ROW_W'(ghc_pkg::ROWS - 1)) &&
                       (col_reg == ghc_pkg::COL_W'(ghc_pkg::COLS - 1));

    always_comb begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        wait_next  = wait_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.row    = row_reg;
        cmd.col    = col_reg;
        if (state_reg == ST_CLEAR || state_reg == ST_STAT || state_reg == ST_HOT) begin
            if (col_reg == ghc_pkg::COL_W'(ghc_pkg::COLS - 1)) begin
                col_next = '0;
                row_next = last_cell ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (last_cell) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    case (in_kind)
                        ghc_pkg::KIND_WRITE:  cmd.wr_item = 1'b1;
                        ghc_pkg::KIND_CLEAR:  state_next = ST_CLEAR;
                        ghc_pkg::KIND_LOCATE: begin
                            cmd.acc_clr = 1'b1;
                            state_next  = ST_STAT;
                        end
                        default: ;
                    endcase
                end
            end
            ST_STAT: begin
                cmd.sweep_rd = 1'b1;
                wait_next    = '0;
                if (last_cell) state_next = ST_STAT_DRAIN;
            end
            ST_STAT_DRAIN: begin
                wait_next = wait_reg + 1'b1;
                if (wait_reg == ghc_pkg::WAIT_W'(ghc_pkg::STAT_DRAIN - 1)) begin
                    wait_next  = '0;
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                wait_next = wait_reg + 1'b1;
                if (wait_reg == ghc_pkg::WAIT_W'(ghc_pkg::CALC_WAIT - 1)) begin
                    wait_next  = '0;
                    state_next = ST_HOT;
                end
            end
            ST_HOT: begin
                cmd.sweep_rd = 1'b1;
                cmd.hot_mode = 1'b1;
                wait_next    = '0;
                if (last_cell) state_next = ST_HOT_DRAIN;
            end
            ST_HOT_DRAIN: begin
                cmd.hot_mode = 1'b1;
                wait_next    = wait_reg + 1'b1;
                if (wait_reg == ghc_pkg::WAIT_W'(ghc_pkg::HOT_DRAIN - 1)) begin
                    wait_next  = '0;
                    state_next = stat.hot_none ? ST_OUT : ST_DIVR;
                end
            end
            ST_DIVR: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIVR_WAIT;
            end
            ST_DIVR_WAIT: begin
                if (stat.div_done) begin
                    cmd.load_qr = 1'b1;
                    state_next  = ST_DIVC;
                end
            end
            ST_DIVC: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = 1'b1;
                state_next    = ST_DIVC_WAIT;
            end
            ST_DIVC_WAIT: begin
                cmd.div_sel = 1'b1;
                if (stat.div_done) begin
                    cmd.load_qc = 1'b1;
                    state_next  = ST_OUT;
                end
            end
            ST_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            row_reg   <= '0;
            col_reg   <= '0;
            wait_reg  <= '0;
        end else begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            wait_reg  <= wait_next;
        end
    end
endmodule
`default_nettype wire

[sv/grid_hotspot_centroid.sv]
// Grid hot-spot centroid, top level: stream ports, threshold register, controller and datapath.
// A write request is written to the sample memory as it is taken, a clear request sweeps
// the whole grid, and after reset the same clearing pass runs before the first request is
// taken. A locate request runs through these steps after it is taken (both divisions are
// skipped when no cell is hot):
// one sweep of the sample memory for sum and sum of squares, a short pipeline
// for the variance threshold, a second sweep that tests and counts hot cells, and two passes
// of a one-bit-per-cycle divider for the centroid. The result waits in an output register,
// so the next request is taken while it is still held.
// depends on ghc_pkg, ghc_ctrl, ghc_dp
`default_nettype none
module grid_hotspot_centroid (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [ghc_pkg::S_DATA_W-1:0]   s_tdata,   // kind, row, col, sample
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [ghc_pkg::M_DATA_W-1:0]        m_tdata,   // found, hot_count, center_row_q8, center_col_q8
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [ghc_pkg::APB_A_W-1:0]    paddr,
    input  wire logic [ghc_pkg::APB_D_W-1:0]    pwdata,
    output logic [ghc_pkg::APB_D_W-1:0]         prdata,
    output logic                                pready
);
    logic [ghc_pkg::K_W-1:0] factor_reg, factor_next;
    ghc_pkg::ghc_cmd_t       cmd;
    ghc_pkg::ghc_stat_t      stat;
    logic                    cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = paddr == ghc_pkg::REG_ADDR_THRESHOLD;

    always_comb begin
        factor_next = factor_reg;
        if (psel && penable && pwrite && cfg_hit) factor_next = pwdata[ghc_pkg::K_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) factor_reg <= ghc_pkg::K_RESET;
        else          factor_reg <= factor_next;
    end

    assign prdata = cfg_hit ? ghc_pkg::APB_D_W'(factor_reg) : '0;

    ghc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_kind  (s_tdata[1:0]),
        .in_ready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    ghc_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_row    (s_tdata[5:2]),
        .in_col    (s_tdata[11:6]),
        .in_sample (s_tdata[27:12]),
        .factor    (factor_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );
endmodule
`default_nettype wire
